>>> rtl/bdod_pkg.sv
// Shared types and constants for the bass drop onset detector.
// No dependencies; used by every module under rtl/.
package bdod_pkg;

  // ring and stream geometry
  localparam int WINDOW_DEPTH = 512;
  localparam int MAX_DROPS    = 16;
  localparam int AW           = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = AW + 1;
  localparam int LEVEL_W      = 16;
  localparam int SUM_W        = LEVEL_W + AW;
  localparam int FRAME_W      = 20;
  localparam int DROP_W       = 5;
  localparam int WIN_CFG_W    = 10;
  localparam int CFG_W        = 20;
  localparam int CFG_IDX_W    = 1;
  localparam int PROD_W       = LEVEL_W + FILL_W + 3;

  // 0.25 in Q2.14, and 1.6 written as RATIO_NUM / RATIO_DEN
  localparam logic [LEVEL_W-1:0] HOT_FLOOR = LEVEL_W'(4096);
  localparam int RATIO_NUM = 8;
  localparam int RATIO_DEN = 5;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_FRAMES = 1'b1;

  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = WIN_CFG_W'(120);

  // one frame request as it moves from the ring stage to the decision stage
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               new_track;
    logic [FILL_W-1:0]  fill;
    logic               evict;
  } stage_t;

endpackage

>>> rtl/bass_drop_onset_detector_core.sv
// Bass drop onset detector, top level.
// Usage:
//   in_*  : one bass level per video frame; in_tdata[15:0] is the level in
//           unsigned Q2.14, in_tuser marks the first frame of a new track,
//           which clears all track state before that frame is judged.
//   out_* : one request per detected drop; out_tdata holds the frame index
//           and the drop ordinal, out_tlast marks the drop that reaches the
//           drop limit, after which no drops come until the next track.
//   cfg_* : write window_frames (index 0) or min_gap_frames (index 1) while
//           the block is idle.
// Throughput: one frame per cycle while out_tready keeps the output register free.
//   The ring memory is read and written in the accept cycle; the test and the
//   window sum update run in the decision stage, and a drop then waits in the output register.
// Reset (rst_n low, synchronous) empties the window and the drop count and
//   restores the register defaults; ring contents are not cleared, and a
//   stale slot's value is never used before that slot is written.
// When out_tready is low with a drop waiting, one more frame is held in the
//   decision stage and in_tready drops until the drop is taken.
// Depends on bdod_pkg, bdod_ring, bdod_detect.
module bass_drop_onset_detector_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] bass_level
  input  logic                              in_tuser,   // [0] new_track
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [19:0] drop_frame, [24:20] drop_number
  output logic                              out_tlast,  // final_drop
  input  logic                              cfg_we,
  input  logic [bdod_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdod_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [bdod_pkg::WIN_CFG_W-1:0] win_cfg_r;
  logic [bdod_pkg::CFG_W-1:0]     gap_cfg_r;

  logic                           s1_valid_r, s1_valid_nxt;
  logic                           out_valid_r;
  logic [bdod_pkg::FRAME_W-1:0]   out_frame_r;
  logic [bdod_pkg::DROP_W-1:0]    out_number_r;
  logic                           out_final_r;

  logic                           out_free, s1_go, in_fire;
  bdod_pkg::stage_t               stage;
  logic [bdod_pkg::LEVEL_W-1:0]   old_level;
  logic                           emit;
  logic [bdod_pkg::FRAME_W-1:0]   drop_frame;
  logic [bdod_pkg::DROP_W-1:0]    drop_number;
  logic                           final_drop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= bdod_pkg::WINDOW_RESET;
      gap_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdod_pkg::REG_WINDOW_FRAMES:  win_cfg_r <= cfg_wdata[bdod_pkg::WIN_CFG_W-1:0];
        bdod_pkg::REG_MIN_GAP_FRAMES: gap_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: the decision stage moves when the output register can take a request
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  bdod_ring u_ring (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_fire      (in_fire),
    .req_level     (in_tdata),
    .req_new_track (in_tuser),
    .window_frames (win_cfg_r),
    .stage_o       (stage),
    .old_level_o   (old_level)
  );

  bdod_detect u_detect (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_go),
    .stage_i        (stage),
    .old_level      (old_level),
    .min_gap_frames (gap_cfg_r),
    .emit_o         (emit),
    .drop_frame_o   (drop_frame),
    .drop_number_o  (drop_number),
    .final_drop_o   (final_drop)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_frame_r  <= drop_frame;
      out_number_r <= drop_number;
      out_final_r  <= final_drop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_number_r, out_frame_r};
  assign out_tlast  = out_final_r;

endmodule

>>> rtl/bdod_ring.sv
// Level ring memory with its write pointer and fill count.
// Reads the oldest entry and writes the new level in the same cycle.
// Depends on bdod_pkg.
module bdod_ring (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  req_fire,
  input  logic [bdod_pkg::LEVEL_W-1:0]          req_level,
  input  logic                                  req_new_track,
  input  logic [bdod_pkg::WIN_CFG_W-1:0]        window_frames,
  output bdod_pkg::stage_t                      stage_o,
  output logic [bdod_pkg::LEVEL_W-1:0]          old_level_o
);

  logic [bdod_pkg::LEVEL_W-1:0] level_ring_r [bdod_pkg::WINDOW_DEPTH];
  logic [bdod_pkg::AW-1:0]      ptr_r, ptr_nxt;
  logic [bdod_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  bdod_pkg::stage_t             stage_r;
  logic [bdod_pkg::LEVEL_W-1:0] old_level_r;

  logic [bdod_pkg::AW-1:0]      cur_ptr;
  logic [bdod_pkg::FILL_W-1:0]  cur_fill;
  logic [bdod_pkg::FILL_W-1:0]  win_eff;
  logic [bdod_pkg::FILL_W-1:0]  ptr_ext;
  logic [bdod_pkg::FILL_W-1:0]  oldest_ext;
  logic [bdod_pkg::AW-1:0]      oldest_idx;
  logic                         evict;

  // clamp the window length to 1..WINDOW_DEPTH
  always_comb begin
    if (window_frames == '0) begin
      win_eff = bdod_pkg::FILL_W'(1);
    end else if (bdod_pkg::FILL_W'(window_frames) > bdod_pkg::FILL_W'(bdod_pkg::WINDOW_DEPTH))
    begin
      win_eff = bdod_pkg::FILL_W'(bdod_pkg::WINDOW_DEPTH);
    end else begin
      win_eff = bdod_pkg::FILL_W'(window_frames);
    end
  end

  // a new track restarts the ring at slot zero with an empty window
  assign cur_ptr  = req_new_track ? '0 : ptr_r;
  assign cur_fill = req_new_track ? '0 : fill_r;
  assign evict    = (cur_fill >= win_eff);

  // oldest slot = (pointer - fill) mod depth
  assign ptr_ext = bdod_pkg::FILL_W'(cur_ptr);
  always_comb begin
    if (ptr_ext >= cur_fill) begin
      oldest_ext = ptr_ext - cur_fill;
    end else begin
      oldest_ext = ptr_ext + bdod_pkg::FILL_W'(bdod_pkg::WINDOW_DEPTH) - cur_fill;
    end
  end
  assign oldest_idx = oldest_ext[bdod_pkg::AW-1:0];

  assign fill_nxt = evict ? cur_fill : cur_fill + bdod_pkg::FILL_W'(1);
  assign ptr_nxt  = (cur_ptr == bdod_pkg::AW'(bdod_pkg::WINDOW_DEPTH - 1))
                    ? '0 : cur_ptr + bdod_pkg::AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
    end else if (req_fire) begin
      ptr_r  <= ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // read-first: a full-depth window reads the old value of the slot it overwrites
  always_ff @(posedge clk) begin
    if (req_fire) begin
      old_level_r           <= level_ring_r[oldest_idx];
      level_ring_r[cur_ptr] <= req_level;
    end
  end

  // request payload for the decision stage
  always_ff @(posedge clk) begin
    if (req_fire) begin
      stage_r.level     <= req_level;
      stage_r.new_track <= req_new_track;
      stage_r.fill      <= cur_fill;
      stage_r.evict     <= evict;
    end
  end

  assign stage_o     = stage_r;
  assign old_level_o = old_level_r;

endmodule

>>> rtl/bdod_detect.sv
// Threshold test, window sum update and drop bookkeeping for one frame.
// Takes the request and the evicted level from bdod_ring. Depends on bdod_pkg.
module bdod_detect (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  bdod_pkg::stage_t                 stage_i,
  input  logic [bdod_pkg::LEVEL_W-1:0]     old_level,
  input  logic [bdod_pkg::CFG_W-1:0]       min_gap_frames,
  output logic                             emit_o,
  output logic [bdod_pkg::FRAME_W-1:0]     drop_frame_o,
  output logic [bdod_pkg::DROP_W-1:0]      drop_number_o,
  output logic                             final_drop_o
);

  logic [bdod_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic                         above_r;
  logic [bdod_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [bdod_pkg::FRAME_W-1:0] last_r;
  logic [bdod_pkg::DROP_W-1:0]  drops_r, drops_nxt;

  logic [bdod_pkg::SUM_W-1:0]   cur_sum;
  logic                         cur_above;
  logic [bdod_pkg::FRAME_W-1:0] cur_frame, cur_last, gap;
  logic [bdod_pkg::DROP_W-1:0]  cur_drops;
  logic                         limit;
  logic [bdod_pkg::PROD_W-1:0]  lhs, rhs;
  logic                         hot;
  logic                         emit;

  // a new track sees all-zero state
  assign cur_sum   = stage_i.new_track ? '0 : sum_r;
  assign cur_above = stage_i.new_track ? 1'b0 : above_r;
  assign cur_frame = stage_i.new_track ? '0 : frame_r;
  assign cur_last  = stage_i.new_track ? '0 : last_r;
  assign cur_drops = stage_i.new_track ? '0 : drops_r;
  assign limit     = (cur_drops >= bdod_pkg::DROP_W'(bdod_pkg::MAX_DROPS));

  // hot: level above the floor and either an empty window or 5*level*fill > 8*sum
  assign lhs = bdod_pkg::PROD_W'(stage_i.level) * bdod_pkg::PROD_W'(stage_i.fill)
               * bdod_pkg::PROD_W'(bdod_pkg::RATIO_DEN);
  assign rhs = bdod_pkg::PROD_W'(cur_sum) * bdod_pkg::PROD_W'(bdod_pkg::RATIO_NUM);
  assign hot = (stage_i.level > bdod_pkg::HOT_FLOOR) &&
               ((stage_i.fill == '0) || (lhs > rhs));

  // rising edge of hot, spaced by the minimum gap
  assign gap  = cur_frame - cur_last;
  assign emit = !limit && hot && !cur_above &&
                ((cur_drops == '0) || (bdod_pkg::CFG_W'(gap) >= min_gap_frames));

  assign drops_nxt = cur_drops + bdod_pkg::DROP_W'(1);
  assign sum_nxt   = cur_sum + bdod_pkg::SUM_W'(stage_i.level)
                     - (stage_i.evict ? bdod_pkg::SUM_W'(old_level) : '0);
  assign frame_nxt = (cur_frame == bdod_pkg::FRAME_MAX) ? cur_frame
                     : cur_frame + bdod_pkg::FRAME_W'(1);

  // state update; frames past the drop limit leave it alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      above_r <= 1'b0;
      frame_r <= '0;
      last_r  <= '0;
      drops_r <= '0;
    end else if (step) begin
      if (limit) begin
        sum_r   <= cur_sum;
        above_r <= cur_above;
        frame_r <= cur_frame;
        last_r  <= cur_last;
        drops_r <= cur_drops;
      end else begin
        sum_r   <= sum_nxt;
        above_r <= hot;
        frame_r <= frame_nxt;
        last_r  <= emit ? cur_frame : cur_last;
        drops_r <= emit ? drops_nxt : cur_drops;
      end
    end
  end

  assign emit_o        = emit;
  assign drop_frame_o  = cur_frame;
  assign drop_number_o = drops_nxt;
  assign final_drop_o  = (drops_nxt == bdod_pkg::DROP_W'(bdod_pkg::MAX_DROPS));

endmodule

>>> verif/tb_bass_drop_onset_detector_core.sv
// Self-checking testbench for bass_drop_onset_detector_core: streams frame
// levels through in_*, predicts drop requests and checks every one on out_*.
// Depends on bdod_pkg and the RTL under rtl/.
module tb_bass_drop_onset_detector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 4;

  // one expected drop request
  typedef struct packed {
    logic [bdod_pkg::FRAME_W-1:0] frame_idx;
    logic [bdod_pkg::DROP_W-1:0]  ordinal;
    logic                         is_final;
  } drop_t;

  // Drop predictor and checker: tracks window, ring and drop state per frame
  class drop_scoreboard;
    logic [bdod_pkg::LEVEL_W-1:0]   ring [bdod_pkg::WINDOW_DEPTH];
    int unsigned                    sum, fill, ptr, frame, last_at, drops;
    bit                             above;
    logic [bdod_pkg::WIN_CFG_W-1:0] win_cfg;
    logic [bdod_pkg::FRAME_W-1:0]   gap_cfg;
    drop_t                          expected_drops[$];
    int                             errors;

    function void clear_track();
      foreach (ring[i]) ring[i] = '0;
      sum = 0;
      fill = 0;
      ptr = 0;
      above = 1'b0;
      frame = 0;
      last_at = 0;
      drops = 0;
    endfunction

    function void reset();
      clear_track();
      win_cfg = bdod_pkg::WINDOW_RESET;
      gap_cfg = '0;
    endfunction

    function void set_reg(logic [bdod_pkg::CFG_IDX_W-1:0] idx,
                          logic [bdod_pkg::CFG_W-1:0] val);
      if (idx == bdod_pkg::REG_WINDOW_FRAMES) begin
        win_cfg = val[bdod_pkg::WIN_CFG_W-1:0];
      end else begin
        gap_cfg = val[bdod_pkg::FRAME_W-1:0];
      end
    endfunction

    // predict the outcome of one accepted frame request
    function void note_frame(logic [bdod_pkg::LEVEL_W-1:0] level, logic nt);
      int unsigned     win, oldest, fill_new;
      longint unsigned lhs, rhs;
      bit              hot, emit;
      drop_t           d;
      if (nt) clear_track();
      // detection frozen once the drop limit is reached
      if (drops >= bdod_pkg::MAX_DROPS) return;
      win = win_cfg;
      if (win < 1) win = 1;
      if (win > bdod_pkg::WINDOW_DEPTH) win = bdod_pkg::WINDOW_DEPTH;
      // hot: above floor and above 1.6x trailing mean (empty window means 0)
      hot = level > bdod_pkg::HOT_FLOOR;
      lhs = 64'd5 * level * fill;
      rhs = 64'd8 * sum;
      if (hot && fill > 0) hot = lhs > rhs;
      emit = hot && !above && (drops == 0 || (frame - last_at) >= gap_cfg);
      if (emit) begin
        drops++;
        last_at = frame;
        d.frame_idx = frame[bdod_pkg::FRAME_W-1:0];
        d.ordinal = drops[bdod_pkg::DROP_W-1:0];
        d.is_final = (drops >= bdod_pkg::MAX_DROPS);
        expected_drops.insert(expected_drops.size(), d);
      end
      above = hot;
      // window update: oldest entry leaves only when the window is full
      oldest = (ptr + bdod_pkg::WINDOW_DEPTH - fill) % bdod_pkg::WINDOW_DEPTH;
      fill_new = fill + 1;
      sum += level;
      if (fill_new > win) begin
        sum -= ring[oldest];
        fill_new--;
      end
      ring[ptr] = level;
      ptr = (ptr + 1) % bdod_pkg::WINDOW_DEPTH;
      fill = fill_new;
      if (frame < bdod_pkg::FRAME_MAX) frame++;
    endfunction

    // compare one accepted drop request with the oldest prediction
    function void check_drop(logic [31:0] tdata, logic tlast);
      drop_t                        want;
      logic [bdod_pkg::FRAME_W-1:0] got_frame;
      logic [bdod_pkg::DROP_W-1:0]  got_num;
      got_frame = tdata[bdod_pkg::FRAME_W-1:0];
      got_num = tdata[bdod_pkg::FRAME_W +: bdod_pkg::DROP_W];
      if (expected_drops.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected drop: expected none, actual frame %0d number %0d final %0d",
                 $time, got_frame, got_num, tlast);
        return;
      end
      want = expected_drops.pop_front();
      if (want.frame_idx !== got_frame) begin
        errors++;
        $display("%0t ERROR drop_frame: expected %0d, actual %0d",
                 $time, want.frame_idx, got_frame);
      end
      if (want.ordinal !== got_num) begin
        errors++;
        $display("%0t ERROR drop_number: expected %0d, actual %0d",
                 $time, want.ordinal, got_num);
      end
      if (want.is_final !== tlast) begin
        errors++;
        $display("%0t ERROR final_drop: expected %0d, actual %0d",
                 $time, want.is_final, tlast);
      end
    endfunction

    function int pending();
      return expected_drops.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [15:0]                    in_tdata;   // [15:0] bass_level
  logic                           in_tuser;   // [0] new_track
  logic                           out_tvalid;
  logic                           out_tready;
  logic [31:0]                    out_tdata;  // [19:0] drop_frame, [24:20] drop_number
  logic                           out_tlast;  // final_drop
  logic                           cfg_we;
  logic [bdod_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bdod_pkg::CFG_W-1:0]     cfg_wdata;

  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;
  int stall_left;
  int quiet_left;
  int spike_left;

  drop_scoreboard sb = new();

  bass_drop_onset_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous overall limit
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // monitor both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_drop(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_frame(in_tdata, in_tuser);
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // offer one frame request, with an optional idle burst first
  task automatic send_frame(input logic [bdod_pkg::LEVEL_W-1:0] lvl, input logic nt);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= lvl;
    in_tuser <= nt;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every predicted drop has come out
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdod_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdod_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_phase(input int win, input int gap);
    settle();
    write_reg(bdod_pkg::REG_WINDOW_FRAMES, bdod_pkg::CFG_W'(win));
    write_reg(bdod_pkg::REG_MIN_GAP_FRAMES, bdod_pkg::CFG_W'(gap));
  endtask

  // quiet stretches broken by short spikes, with some full-range noise
  task automatic run_pulses(input int count, input int nt_odds);
    logic [bdod_pkg::LEVEL_W-1:0] lvl;
    logic                         nt;
    for (int i = 0; i < count; i++) begin
      nt = (nt_odds > 0) && ($urandom_range(1, nt_odds) == 1);
      if ($urandom_range(0, 9) == 0) begin
        lvl = bdod_pkg::LEVEL_W'($urandom);
      end else if (spike_left > 0) begin
        lvl = bdod_pkg::LEVEL_W'($urandom_range(6000, 65535));
        spike_left--;
      end else if (quiet_left > 0) begin
        lvl = bdod_pkg::LEVEL_W'($urandom_range(0, 3000));
        quiet_left--;
      end else begin
        spike_left = $urandom_range(1, 3);
        quiet_left = $urandom_range(1, 12);
        lvl = bdod_pkg::LEVEL_W'($urandom_range(0, 3000));
      end
      send_frame(lvl, nt);
    end
  endtask

  initial begin
    sb.reset();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bdod_pkg::REG_WINDOW_FRAMES;
    cfg_wdata = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req = 1'b0;
    quiet_left = 0;
    spike_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // directed: floor edge, ratio equality, extremes, new track mid-stream
    send_frame(16'd0, 1'b1);
    send_frame(16'd4096, 1'b0);
    send_frame(16'd4097, 1'b0);
    send_frame(16'd4097, 1'b0);
    send_frame(16'd0, 1'b0);
    send_frame(16'd65535, 1'b0);
    send_frame(16'd65535, 1'b0);
    send_frame(16'd0, 1'b0);
    send_frame(16'd65535, 1'b1);
    send_frame(16'd0, 1'b0);
    send_frame(16'd1, 1'b0);
    send_frame(16'd65535, 1'b0);
    send_frame(16'd8000, 1'b1);
    send_frame(16'd12800, 1'b0);
    send_frame(16'd16641, 1'b0);
    send_frame(16'd0, 1'b0);
    send_frame(16'd32768, 1'b0);
    send_frame(16'd21845, 1'b0);
    send_frame(16'd43690, 1'b0);
    send_frame(16'd65535, 1'b1);

    // random phases over several register settings
    run_pulses(110, 40);
    set_phase(1, 0);
    run_pulses(100, 120);
    set_phase(0, 3);
    run_pulses(70, 50);
    set_phase(bdod_pkg::WINDOW_DEPTH, 10);
    run_pulses(130, 0);
    // shrink the window without a new track
    set_phase(8, 0);
    run_pulses(60, 0);
    set_phase(1023, int'(bdod_pkg::FRAME_MAX));
    run_pulses(50, 25);

    // long receiver hold while the sender keeps offering
    set_phase(1, 0);
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    run_pulses(60, 0);

    // closing stretch with no idling on either side
    set_phase(37, 2);
    rx_idle_en = 1'b0;
    run_pulses(80, 40);

    settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
